// ----- hw/rtl/xxtea_pkg.sv -----
`default_nettype none

package xxtea_pkg;

  // block geometry and round count
  localparam int BLOCK_WORDS = 5;
  localparam int ROUNDS      = 6;
  localparam int STEPS       = ROUNDS * BLOCK_WORDS;
  localparam int POS_W       = (BLOCK_WORDS > 2) ? $clog2(BLOCK_WORDS) : 1;
  localparam int KEY_WORDS   = 4;
  localparam int CFG_INDEX_W = 3;

  // golden-ratio delta and the starting sum for decryption
  localparam logic [31:0] DELTA        = 32'h9e37_79b9;
  localparam logic [63:0] SUM_DEC_WIDE = 64'(ROUNDS) * 64'h9e37_79b9;
  localparam logic [31:0] SUM_DEC_INIT = SUM_DEC_WIDE[31:0];

  typedef logic [31:0] word_t;
  typedef word_t [BLOCK_WORDS-1:0] block_t;
  typedef word_t [KEY_WORDS-1:0] key_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  // payload carried from cell to cell: words are kept rotated so that
  // the word being updated always sits in slot 0
  typedef struct packed {
    op_e               op;
    word_t             sum;
    logic [POS_W-1:0]  pos;
    block_t            words;
  } stage_t;

endpackage

`default_nettype wire

// ----- hw/rtl/xxtea_cell.sv -----
`default_nettype none

module xxtea_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  xxtea_pkg::key_t       key_i,
  input  wire                   valid_i,
  input  xxtea_pkg::stage_t     stage_i,
  output logic                  valid_o,
  output xxtea_pkg::stage_t     stage_o
);
  import xxtea_pkg::*;

  logic              valid_q;
  stage_t            stage_q;
  stage_t            stage_d;
  word_t             target;
  word_t             z;
  word_t             y;
  word_t             mix_a;
  word_t             mix_b;
  word_t             mix;
  word_t             upd;
  word_t             pos_ext;
  logic [1:0]        key_sel;
  logic              last_pos;
  logic              first_pos;

  // neighbors of the updated word in the rotated block
  assign target = stage_i.words[0];
  assign z      = stage_i.words[BLOCK_WORDS-1];
  assign y      = stage_i.words[1];

  // key word select from position and sum
  assign pos_ext = 32'(stage_i.pos);
  assign key_sel = pos_ext[1:0] ^ stage_i.sum[3:2];

  // xxtea mix
  assign mix_a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
  assign mix_b = (stage_i.sum ^ y) + (key_i[key_sel] ^ z);
  assign mix   = mix_a ^ mix_b;
  assign upd   = (stage_i.op == OP_DECRYPT) ? (target - mix) : (target + mix);

  assign last_pos  = (stage_i.pos == POS_W'(BLOCK_WORDS - 1));
  assign first_pos = (stage_i.pos == '0);

  // rotate and step position and sum
  always_comb begin
    stage_d    = stage_i;
    if (stage_i.op == OP_DECRYPT) begin
      stage_d.words[0] = stage_i.words[BLOCK_WORDS-1];
      stage_d.words[1] = upd;
      for (int i = 2; i < BLOCK_WORDS; i++) begin
        stage_d.words[i] = stage_i.words[i-1];
      end
      stage_d.pos = first_pos ? POS_W'(BLOCK_WORDS - 1) : stage_i.pos - 1'b1;
      stage_d.sum = first_pos ? stage_i.sum - DELTA : stage_i.sum;
    end else begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        stage_d.words[i] = stage_i.words[i+1];
      end
      stage_d.words[BLOCK_WORDS-1] = upd;
      stage_d.pos = last_pos ? '0 : stage_i.pos + 1'b1;
      stage_d.sum = last_pos ? stage_i.sum + DELTA : stage_i.sum;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- hw/rtl/xxtea_block_cipher.sv -----
`default_nettype none

// channel   direction  handshake                    payload
// request   in         start high, busy low          opcode_i, block_word_0_i..4_i
// result    out        done_o strobe, one cycle      result_word_0_o..4_o
// config    in         cfg_valid_i & cfg_ready_o     cfg_index_i, cfg_data_i
//
// a row of 30 cells (six rounds of five word updates), one word update per cell
// every request gives its result after it has passed through the payload register of every cell in the row
// a new request is taken in every cycle, busy stays low
// reset clears all valid flags and the key to all zero; no clearing pass
// results cannot be stalled, the receiver takes each one as it is shown

module xxtea_block_cipher (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  wire                                opcode_i,
  input  wire  [31:0]                        block_word_0_i,
  input  wire  [31:0]                        block_word_1_i,
  input  wire  [31:0]                        block_word_2_i,
  input  wire  [31:0]                        block_word_3_i,
  input  wire  [31:0]                        block_word_4_i,
  output logic                               done_o,
  output logic [31:0]                        result_word_0_o,
  output logic [31:0]                        result_word_1_o,
  output logic [31:0]                        result_word_2_o,
  output logic [31:0]                        result_word_3_o,
  output logic [31:0]                        result_word_4_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [xxtea_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire  [31:0]                        cfg_data_i
);
  import xxtea_pkg::*;

  key_t              key_q;
  block_t            block_in;
  block_t            block_out;
  block_t            last_words;
  stage_t            head;
  logic              head_valid;
  logic   [STEPS:0]  link_valid;
  stage_t [STEPS:0]  link;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // key registers, writes beyond the key words are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_INDEX_W'(KEY_WORDS))) begin
      key_q[cfg_index_i[1:0]] <= cfg_data_i;
    end
  end

  assign block_in[0] = block_word_0_i;
  assign block_in[1] = block_word_1_i;
  assign block_in[2] = block_word_2_i;
  assign block_in[3] = block_word_3_i;
  assign block_in[4] = block_word_4_i;

  // load the first cell: decryption starts on the last word, rotated right once
  always_comb begin
    head.op = op_e'(opcode_i);
    if (opcode_i == OP_DECRYPT) begin
      head.sum      = SUM_DEC_INIT;
      head.pos      = POS_W'(BLOCK_WORDS - 1);
      head.words[0] = block_in[BLOCK_WORDS-1];
      for (int i = 1; i < BLOCK_WORDS; i++) begin
        head.words[i] = block_in[i-1];
      end
    end else begin
      head.sum   = DELTA;
      head.pos   = '0;
      head.words = block_in;
    end
  end

  assign head_valid    = start && !busy;
  assign link_valid[0] = head_valid;
  assign link[0]       = head;

  // row of cells
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    xxtea_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .valid_i (link_valid[g]),
      .stage_i (link[g]),
      .valid_o (link_valid[g+1]),
      .stage_o (link[g+1])
    );
  end

  // undo the rotation of a decrypted block
  assign last_words = link[STEPS].words;
  always_comb begin
    if (link[STEPS].op == OP_DECRYPT) begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        block_out[i] = last_words[(i + 1) % BLOCK_WORDS];
      end
    end else begin
      block_out = last_words;
    end
  end

  assign done_o          = link_valid[STEPS];
  assign result_word_0_o = block_out[0];
  assign result_word_1_o = block_out[1];
  assign result_word_2_o = block_out[2];
  assign result_word_3_o = block_out[3];
  assign result_word_4_o = block_out[4];

endmodule

`default_nettype wire

// ----- hw/rtl/xxtea_checker.sv -----
`default_nettype none

module xxtea_checker (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  input  wire                                busy,
  input  wire                                done_o
);
  import xxtea_pkg::*;

  logic req_taken;
  assign req_taken = start && !busy;

  // every request gives a result after the fixed latency
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_taken |-> ##STEPS done_o)
    else $error("request without result at fixed latency");

  // no result without a request taken at the fixed latency
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_taken, STEPS))
    else $error("result without matching request");

  // no result strobe while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !done_o)
    else $error("result strobe during reset");

endmodule

bind xxtea_block_cipher xxtea_checker u_xxtea_checker (.*);

`default_nettype wire
